@@ rtl/bdq_pkg.sv @@
// shared constants, codes and types of the bounded deque
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_COUNT      = 3'd4,
    OP_ERASE      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_FRONT,
    S_RD_BACK,
    S_RD_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [WW-1:0] front_item;
    logic signed [WW-1:0] back_item;
    logic [4:0]           occupancy;
    logic [4:0]           matched;
    logic [1:0]           fault;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/bdq_ifs.sv @@
// item channels of the bounded deque: operation in, result out
`default_nettype none
interface bdq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand_value;

  modport source (output valid, output kind, output operand_value, input ready);
  modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface bdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] front_item;
  logic signed [31:0] back_item;
  logic [4:0]         occupancy;
  logic [4:0]         matched;
  logic [1:0]         fault;

  modport source (output valid, output front_item, output back_item, output occupancy,
                  output matched, output fault, input ready);
  modport sink   (input valid, input front_item, input back_item, input occupancy,
                  input matched, input fault, output ready);
endinterface
`default_nettype wire

@@ rtl/bdq_ram.sv @@
// simple dual port ram, one write and one registered read per cycle
`default_nettype none
module bdq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW_P-1:0]    wa,
  input  wire logic [WIDTH_P-1:0] wd,
  input  wire logic [AW_P-1:0]    ra,
  output logic      [WIDTH_P-1:0] rd
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

@@ rtl/bdq_ctrl.sv @@
// operation sequencer: ring pointers, scan and compaction, end readback
`default_nettype none
module bdq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bdq_in_if.sink                      in_ch,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output bdq_pkg::res_t               res,
  output logic                        mem_we,
  output logic [bdq_pkg::AW-1:0]      mem_wa,
  output logic [bdq_pkg::WW-1:0]      mem_wd,
  output logic [bdq_pkg::AW-1:0]      mem_ra,
  input  wire logic [bdq_pkg::WW-1:0] mem_rd
);
  import bdq_pkg::*;

  localparam int SW = CW + 1;

  // ring address of logical position b, counted from a
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  state_t        state_r, state_nxt, start_state;
  logic [AW-1:0] head_r, head_nxt, head_dec;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] hits_r, hits_nxt;
  logic          pend_r, pend_nxt;
  op_t           kind_r, kind_nxt;
  logic [WW-1:0] opnd_r, opnd_nxt;
  logic [WW-1:0] front_r, front_nxt;
  logic [WW-1:0] back_r, back_nxt;
  fault_t        fault_r, fault_nxt;
  logic          full, empty, scan_done;

  assign full      = (fill_r == CW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : AW'(head_r - 1'b1);
  assign scan_done = (idx_r == fill_r) && !pend_r;

  always_comb begin
    unique case (op_t'(in_ch.kind))
      OP_PUSH_FRONT, OP_PUSH_BACK: start_state = full ? S_DONE : S_RD_FRONT;
      OP_POP_FRONT, OP_POP_BACK:   start_state = empty ? S_DONE : S_RD_FRONT;
      OP_COUNT, OP_ERASE:          start_state = empty ? S_DONE : S_SCAN;
      default:                     start_state = S_DONE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_ch.valid) state_nxt = start_state;
      S_SCAN:     if (scan_done) state_nxt = (kind_r == OP_ERASE) ? S_RD_FRONT : S_DONE;
      S_RD_FRONT: state_nxt = (fill_r == '0) ? S_DONE : S_RD_BACK;
      S_RD_BACK:  state_nxt = S_RD_WAIT;
      S_RD_WAIT:  state_nxt = S_DONE;
      S_DONE:     if (res_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    kept_nxt  = kept_r;
    hits_nxt  = hits_r;
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    opnd_nxt  = opnd_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    fault_nxt = fault_r;
    mem_we    = 1'b0;
    mem_wa    = head_r;
    mem_wd    = opnd_r;
    mem_ra    = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = op_t'(in_ch.kind);
          opnd_nxt  = in_ch.operand_value;
          idx_nxt   = '0;
          kept_nxt  = '0;
          hits_nxt  = '0;
          pend_nxt  = 1'b0;
          fault_nxt = FAULT_NONE;
          mem_wd    = in_ch.operand_value;
          unique case (op_t'(in_ch.kind))
            OP_PUSH_FRONT: begin
              if (full) begin
                fault_nxt = FAULT_OVERFLOW;
              end else begin
                head_nxt = head_dec;
                mem_we   = 1'b1;
                mem_wa   = head_dec;
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                fault_nxt = FAULT_OVERFLOW;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = ring_add(head_r, fill_r);
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                fault_nxt = FAULT_UNDERFLOW;
              end else begin
                head_nxt = ring_add(head_r, CW'(1));
                fill_nxt = fill_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                fault_nxt = FAULT_UNDERFLOW;
              end else begin
                fill_nxt = fill_r - 1'b1;
              end
            end
            OP_ERASE: begin
              if (empty) fault_nxt = FAULT_UNDERFLOW;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // issue next read, then judge the word that came back
        if (idx_r != fill_r) begin
          mem_ra   = ring_add(head_r, idx_r);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (mem_rd == opnd_r) begin
            hits_nxt = hits_r + 1'b1;
          end else if (kind_r == OP_ERASE) begin
            mem_we   = 1'b1;
            mem_wa   = ring_add(head_r, kept_r);
            mem_wd   = mem_rd;
            kept_nxt = kept_r + 1'b1;
          end
        end
        if (scan_done && kind_r == OP_ERASE) begin
          fill_nxt = kept_r;
        end
      end
      S_RD_FRONT: begin
        if (fill_r == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
        end
        mem_ra = head_r;
      end
      S_RD_BACK: begin
        mem_ra    = ring_add(head_r, CW'(fill_r - 1'b1));
        front_nxt = mem_rd;
      end
      S_RD_WAIT: begin
        back_nxt = mem_rd;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_DONE);
  assign res.front_item = front_r;
  assign res.back_item  = back_r;
  assign res.occupancy  = 5'(fill_r);
  assign res.matched    = 5'(hits_r);
  assign res.fault      = fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      front_r <= '0;
      back_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    kept_r  <= kept_nxt;
    hits_r  <= hits_nxt;
    pend_r  <= pend_nxt;
    kind_r  <= kind_nxt;
    opnd_r  <= opnd_nxt;
    fault_r <= fault_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (kept_r <= idx_r) && (hits_r + kept_r <= idx_r))
    else $error("compaction write ahead of scan read");

  a_no_write_readback: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_SCAN))
    else $error("memory written during readback");

  a_overflow_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && full &&
     (in_ch.kind == OP_PUSH_FRONT || in_ch.kind == OP_PUSH_BACK))
    |=> $stable(fill_r) && $stable(head_r) && fault_r == FAULT_OVERFLOW)
    else $error("dropped push changed the sequence");

endmodule
`default_nettype wire

@@ rtl/bounded_deque_with_match_erase.sv @@
// top level of the bounded deque with match count and match erase
//
//  channel  dir  handshake              payload
//  in_ch    in   valid / ready          kind, operand_value
//  out_ch   out  valid / ready          front_item, back_item, occupancy, matched, fault
//
// one item in flight: push and pop read back the front and back items (a pop that
// empties the deque skips it); faults, no-op kinds and a count on an empty deque go
// straight to the result; count scans every word, and erase scans, compacts and reads
// both ends (not when nothing survives); scan and readback share the one memory read port
// rst_n is synchronous: occupancy drops to zero, memory contents are kept as garbage
// the result sits in an output register; a new item is taken while it waits
`default_nettype none
module bounded_deque_with_match_erase (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic [WW-1:0] mem_rd;

  // result register toward the output side
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic load;

  // word store, a ring addressed from the head pointer
  bdq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WW),
    .AW_P    (AW)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  // sequencer: pointer update, scan and compaction, readback of both ends
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_ra    (mem_ra),
    .mem_rd    (mem_rd)
  );

  // slot is free when empty or when its item leaves this cycle
  assign res_ready = !out_valid_r || out_ch.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.front_item = out_res_r.front_item;
  assign out_ch.back_item  = out_res_r.back_item;
  assign out_ch.occupancy  = out_res_r.occupancy;
  assign out_ch.matched    = out_res_r.matched;
  assign out_ch.fault      = out_res_r.fault;

endmodule
`default_nettype wire
